/* src/io_soft_switch_bank_control_macros.svh */
// ----------------------------------------------------------------------------
// io soft switch bank control assertion macros
// shared assertion forms for the soft switch block
// ----------------------------------------------------------------------------
`ifndef IO_SOFT_SWITCH_BANK_CONTROL_MACROS_SVH
`define IO_SOFT_SWITCH_BANK_CONTROL_MACROS_SVH

// condition holds at every edge out of reset
`define IOSSBC_CHECK(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("io soft switch check failed");

// condition in one cycle implies result in the next
`define IOSSBC_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("io soft switch sequence check failed");

`endif

/* src/iossbc_pkg.sv */
// ----------------------------------------------------------------------------
// iossbc_pkg
// types, group codes and flag positions for the io soft switch block
// ----------------------------------------------------------------------------
`default_nettype none

package iossbc_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] io_offset;
    logic [7:0] key_data;
    logic [7:0] anykey_data;
    logic [7:0] vblank_data;
    logic [2:0] buttons;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       aux_read;
    logic       aux_write;
    logic       aux_zero_page;
    logic       internal_slot_rom;
    logic [3:0] lc_mode;
    logic [7:0] switch_flags;
    logic [3:0] annunciators;
    logic       speaker_level;
    logic [1:0] speaker_edges;
    logic       key_strobe_clear;
  } result_t;

  // access mode
  localparam logic MODE_WRITE = 1'b1;

  // switch groups (upper nibble of the offset)
  localparam logic [3:0] GRP_SWITCH  = 4'h0;
  localparam logic [3:0] GRP_STATUS  = 4'h1;
  localparam logic [3:0] GRP_SPEAKER = 4'h3;
  localparam logic [3:0] GRP_DISPLAY = 4'h5;
  localparam logic [3:0] GRP_BUTTON  = 4'h6;
  localparam logic [3:0] GRP_LC      = 4'h8;

  // memory map flag positions
  localparam int MM_RAMRD     = 0;
  localparam int MM_RAMWRT    = 1;
  localparam int MM_INTCXROM  = 2;
  localparam int MM_ALTZP     = 3;
  localparam int MM_SLOTC3ROM = 4;
  localparam int MM_STORE80   = 5;

  // display flag positions
  localparam int DF_COL80      = 0;
  localparam int DF_ALTCHARSET = 1;
  localparam int DF_TEXT       = 2;
  localparam int DF_MIXED      = 3;
  localparam int DF_PAGE2      = 4;
  localparam int DF_HIRES      = 5;

  // language card mode positions
  localparam int LC_READRAM = 0;
  localparam int LC_BANK2   = 1;
  localparam int LC_WREN    = 2;
  localparam int LC_WRB2    = 3;

  localparam logic [7:0] FLAG_SET   = 8'h80;
  localparam logic [7:0] FLAG_CLEAR = 8'h00;
  localparam logic [1:0] EDGES_READ  = 2'd1;
  localparam logic [1:0] EDGES_WRITE = 2'd2;

  function automatic logic [7:0] flag80(input logic b);
    return b ? FLAG_SET : FLAG_CLEAR;
  endfunction

endpackage

`default_nettype wire

/* src/io_soft_switch_bank_control.sv */
// an accepted access reaches its result transaction through the input register, then the result register
// throughput: one access per cycle, sustained, with no stall on the result side
// an input register and a result register part the two handshakes
// reset clears all flags, the speaker level, language card to rom read with
// writes disabled, and empties both registers
// ----------------------------------------------------------------------------
// io_soft_switch_bank_control
// soft switch flags, annunciators, speaker and language card bank decode for
// one access to the io page per transaction
// ----------------------------------------------------------------------------
`default_nettype none
`include "io_soft_switch_bank_control_macros.svh"

module io_soft_switch_bank_control (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  access_valid,
  output logic                 access_stall,
  input  iossbc_pkg::access_t  access,
  output logic                 result_valid,
  input  wire                  result_stall,
  output iossbc_pkg::result_t  result
);

  iossbc_pkg::access_t pending;
  logic                pending_valid;

  logic [5:0] mm_flags;
  logic [5:0] df_flags;
  logic [3:0] annunciator_bits;
  logic [3:0] lc_state;
  logic       speaker_bit;

  logic [5:0] mm_flags_next;
  logic [5:0] df_flags_next;
  logic [3:0] annunciator_bits_next;
  logic [3:0] lc_state_next;
  logic       speaker_bit_next;
  iossbc_pkg::result_t result_next;

  logic accept;
  logic advance;
  logic speaker_read;
  logic lc_bank2_ok;

  assign advance      = pending_valid && (!result_valid || !result_stall);
  assign access_stall = pending_valid && !advance;
  assign accept       = access_valid && !access_stall;

  always_comb begin
    logic       wr;
    logic [3:0] grp;
    logic [3:0] n;
    logic [7:0] rd;
    logic [1:0] edges;
    logic       strobe;
    logic       wren;
    logic       readram;

    wr      = (pending.mode == iossbc_pkg::MODE_WRITE);
    grp     = pending.io_offset[7:4];
    n       = pending.io_offset[3:0];
    rd      = 8'h00;
    edges   = 2'd0;
    strobe  = 1'b0;
    wren    = n[0];
    readram = ~(n[1] ^ n[0]);

    mm_flags_next         = mm_flags;
    df_flags_next         = df_flags;
    annunciator_bits_next = annunciator_bits;
    lc_state_next         = lc_state;
    speaker_bit_next      = speaker_bit;

    case (grp)
      iossbc_pkg::GRP_SWITCH: begin
        if (wr) begin
          case (n[3:1])
            3'd0:    mm_flags_next[iossbc_pkg::MM_STORE80]   = n[0];
            3'd1:    mm_flags_next[iossbc_pkg::MM_RAMRD]     = n[0];
            3'd2:    mm_flags_next[iossbc_pkg::MM_RAMWRT]    = n[0];
            3'd3:    mm_flags_next[iossbc_pkg::MM_INTCXROM]  = n[0];
            3'd4:    mm_flags_next[iossbc_pkg::MM_ALTZP]     = n[0];
            3'd5:    mm_flags_next[iossbc_pkg::MM_SLOTC3ROM] = n[0];
            3'd6:    df_flags_next[iossbc_pkg::DF_COL80]     = n[0];
            default: df_flags_next[iossbc_pkg::DF_ALTCHARSET] = n[0];
          endcase
        end else begin
          rd = pending.key_data;
        end
      end
      iossbc_pkg::GRP_STATUS: begin
        if (wr) begin
          strobe = 1'b1;
        end else begin
          strobe = (n == 4'h0);
          case (n)
            4'h0: rd = pending.anykey_data;
            4'h1: rd = iossbc_pkg::flag80(lc_state[iossbc_pkg::LC_BANK2]);
            4'h2: rd = iossbc_pkg::flag80(lc_state[iossbc_pkg::LC_READRAM]);
            4'h3: rd = iossbc_pkg::flag80(mm_flags[iossbc_pkg::MM_RAMRD]);
            4'h4: rd = iossbc_pkg::flag80(mm_flags[iossbc_pkg::MM_RAMWRT]);
            4'h5: rd = iossbc_pkg::flag80(mm_flags[iossbc_pkg::MM_INTCXROM]);
            4'h6: rd = iossbc_pkg::flag80(mm_flags[iossbc_pkg::MM_ALTZP]);
            4'h7: rd = iossbc_pkg::flag80(mm_flags[iossbc_pkg::MM_SLOTC3ROM]);
            4'h8: rd = iossbc_pkg::flag80(mm_flags[iossbc_pkg::MM_STORE80]);
            4'h9: rd = pending.vblank_data;
            4'hA: rd = iossbc_pkg::flag80(df_flags[iossbc_pkg::DF_TEXT]);
            4'hB: rd = iossbc_pkg::flag80(df_flags[iossbc_pkg::DF_MIXED]);
            4'hC: rd = iossbc_pkg::flag80(df_flags[iossbc_pkg::DF_PAGE2]);
            4'hD: rd = iossbc_pkg::flag80(df_flags[iossbc_pkg::DF_HIRES]);
            4'hE: rd = iossbc_pkg::flag80(df_flags[iossbc_pkg::DF_ALTCHARSET]);
            default: rd = iossbc_pkg::flag80(df_flags[iossbc_pkg::DF_COL80]);
          endcase
        end
      end
      iossbc_pkg::GRP_SPEAKER: begin
        if (wr) begin
          edges = iossbc_pkg::EDGES_WRITE;
        end else begin
          edges            = iossbc_pkg::EDGES_READ;
          speaker_bit_next = ~speaker_bit;
        end
      end
      iossbc_pkg::GRP_DISPLAY: begin
        if (!n[3]) begin
          case (n[2:1])
            2'd0:    df_flags_next[iossbc_pkg::DF_TEXT]  = n[0];
            2'd1:    df_flags_next[iossbc_pkg::DF_MIXED] = n[0];
            2'd2:    df_flags_next[iossbc_pkg::DF_PAGE2] = n[0];
            default: df_flags_next[iossbc_pkg::DF_HIRES] = n[0];
          endcase
        end else if (!wr) begin
          // annunciator set sense is inverted
          annunciator_bits_next[n[2:1]] = ~n[0];
        end
      end
      iossbc_pkg::GRP_BUTTON: begin
        if (!wr) begin
          case (n)
            4'h1:    rd = iossbc_pkg::flag80(pending.buttons[0]);
            4'h2:    rd = iossbc_pkg::flag80(pending.buttons[1]);
            4'h3:    rd = iossbc_pkg::flag80(pending.buttons[2]);
            default: rd = 8'h00;
          endcase
        end
      end
      iossbc_pkg::GRP_LC: begin
        lc_state_next = {wren & ~n[3], wren, readram & ~n[3], readram};
      end
      default: begin
      end
    endcase

    if (wr) begin
      rd = 8'h00;
    end

    result_next.read_data         = rd;
    result_next.aux_read          = mm_flags_next[iossbc_pkg::MM_RAMRD];
    result_next.aux_write         = mm_flags_next[iossbc_pkg::MM_RAMWRT];
    result_next.aux_zero_page     = mm_flags_next[iossbc_pkg::MM_ALTZP];
    result_next.internal_slot_rom = mm_flags_next[iossbc_pkg::MM_INTCXROM];
    result_next.lc_mode           = lc_state_next;
    result_next.switch_flags      = {df_flags_next[iossbc_pkg::DF_HIRES],
                                     df_flags_next[iossbc_pkg::DF_PAGE2],
                                     df_flags_next[iossbc_pkg::DF_MIXED],
                                     df_flags_next[iossbc_pkg::DF_TEXT],
                                     df_flags_next[iossbc_pkg::DF_ALTCHARSET],
                                     df_flags_next[iossbc_pkg::DF_COL80],
                                     mm_flags_next[iossbc_pkg::MM_SLOTC3ROM],
                                     mm_flags_next[iossbc_pkg::MM_STORE80]};
    result_next.annunciators      = annunciator_bits_next;
    result_next.speaker_level     = speaker_bit_next;
    result_next.speaker_edges     = edges;
    result_next.key_strobe_clear  = strobe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid    <= 1'b0;
      result_valid     <= 1'b0;
      mm_flags         <= '0;
      df_flags         <= '0;
      annunciator_bits <= '0;
      lc_state         <= '0;
      speaker_bit      <= 1'b0;
    end else begin
      pending_valid <= accept || (pending_valid && !advance);
      result_valid  <= advance || (result_valid && result_stall);
      if (advance) begin
        mm_flags         <= mm_flags_next;
        df_flags         <= df_flags_next;
        annunciator_bits <= annunciator_bits_next;
        lc_state         <= lc_state_next;
        speaker_bit      <= speaker_bit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending <= access;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign speaker_read = advance && (pending.io_offset[7:4] == iossbc_pkg::GRP_SPEAKER)
                        && (pending.mode != iossbc_pkg::MODE_WRITE);
  assign lc_bank2_ok  = !lc_state[iossbc_pkg::LC_BANK2] || lc_state[iossbc_pkg::LC_READRAM];

  `IOSSBC_CHECK(a_lc_bank2_needs_ram, lc_bank2_ok)
  `IOSSBC_CHECK(a_lc_out_matches, !result_valid || result.lc_mode == lc_state)
  `IOSSBC_CHECK_NEXT(a_advance_fills, advance, result_valid)
  `IOSSBC_CHECK_NEXT(a_speaker_read, speaker_read, speaker_bit != $past(speaker_bit))

endmodule

`default_nettype wire

/* tb/io_soft_switch_bank_control_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_soft_switch_bank_control_tb
// drives io page accesses through the valid/stall handshake, predicts the
// flags, language card mode, speaker and read data of every access, and
// compares each result transaction field by field in order
// ----------------------------------------------------------------------------

module io_soft_switch_bank_control_tb;

  localparam logic MODE_READ        = ~iossbc_pkg::MODE_WRITE;
  localparam int   RANDOM_PER_PHASE = 375;
  localparam int   CYCLE_LIMIT      = 100000;
  localparam int   DRAIN_CYCLES     = 8;

  typedef struct {
    iossbc_pkg::access_t acc;
    logic                typed;
    iossbc_pkg::result_t want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                access_valid;
  logic                access_stall;
  iossbc_pkg::access_t access;
  logic                result_valid;
  logic                result_stall;
  iossbc_pkg::result_t result;

  // predicted block state
  logic [5:0] mm_flags;
  logic [5:0] disp_flags;
  logic [3:0] ann_bits;
  logic [3:0] lc_bits;
  logic       spk_bit;

  iossbc_pkg::result_t pending_results[$];
  stim_row_t           directed_rows[$];
  logic                pin_valid;
  iossbc_pkg::result_t pinned_result;
  int                  in_idle_pct;
  int                  out_idle_pct;
  int                  mismatch_count;
  int                  cycle_count;

  io_soft_switch_bank_control i_dut (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_stall (access_stall),
    .access       (access),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] status_byte(input logic b);
    return b ? iossbc_pkg::FLAG_SET : iossbc_pkg::FLAG_CLEAR;
  endfunction

  function automatic iossbc_pkg::result_t predict_access(input iossbc_pkg::access_t a);
    iossbc_pkg::result_t r;
    logic                wr;
    logic [3:0]          grp;
    logic [3:0]          n;
    r   = '0;
    wr  = (a.mode == iossbc_pkg::MODE_WRITE);
    grp = a.io_offset[7:4];
    n   = a.io_offset[3:0];
    case (grp)
      iossbc_pkg::GRP_SWITCH: begin
        if (wr) begin
          case (n[3:1])
            3'd0: mm_flags[iossbc_pkg::MM_STORE80] = n[0];
            3'd1: mm_flags[iossbc_pkg::MM_RAMRD] = n[0];
            3'd2: mm_flags[iossbc_pkg::MM_RAMWRT] = n[0];
            3'd3: mm_flags[iossbc_pkg::MM_INTCXROM] = n[0];
            3'd4: mm_flags[iossbc_pkg::MM_ALTZP] = n[0];
            3'd5: mm_flags[iossbc_pkg::MM_SLOTC3ROM] = n[0];
            3'd6: disp_flags[iossbc_pkg::DF_COL80] = n[0];
            default: disp_flags[iossbc_pkg::DF_ALTCHARSET] = n[0];
          endcase
        end else begin
          r.read_data = a.key_data;
        end
      end
      iossbc_pkg::GRP_STATUS: begin
        if (wr) begin
          r.key_strobe_clear = 1'b1;
        end else begin
          case (n)
            4'h0: begin
              r.read_data = a.anykey_data;
              r.key_strobe_clear = 1'b1;
            end
            4'h1: r.read_data = status_byte(lc_bits[iossbc_pkg::LC_BANK2]);
            4'h2: r.read_data = status_byte(lc_bits[iossbc_pkg::LC_READRAM]);
            4'h3: r.read_data = status_byte(mm_flags[iossbc_pkg::MM_RAMRD]);
            4'h4: r.read_data = status_byte(mm_flags[iossbc_pkg::MM_RAMWRT]);
            4'h5: r.read_data = status_byte(mm_flags[iossbc_pkg::MM_INTCXROM]);
            4'h6: r.read_data = status_byte(mm_flags[iossbc_pkg::MM_ALTZP]);
            4'h7: r.read_data = status_byte(mm_flags[iossbc_pkg::MM_SLOTC3ROM]);
            4'h8: r.read_data = status_byte(mm_flags[iossbc_pkg::MM_STORE80]);
            4'h9: r.read_data = a.vblank_data;
            4'hA: r.read_data = status_byte(disp_flags[iossbc_pkg::DF_TEXT]);
            4'hB: r.read_data = status_byte(disp_flags[iossbc_pkg::DF_MIXED]);
            4'hC: r.read_data = status_byte(disp_flags[iossbc_pkg::DF_PAGE2]);
            4'hD: r.read_data = status_byte(disp_flags[iossbc_pkg::DF_HIRES]);
            4'hE: r.read_data = status_byte(disp_flags[iossbc_pkg::DF_ALTCHARSET]);
            default: r.read_data = status_byte(disp_flags[iossbc_pkg::DF_COL80]);
          endcase
        end
      end
      iossbc_pkg::GRP_SPEAKER: begin
        // a write toggles twice, so the level only moves on a read
        r.speaker_edges = wr ? iossbc_pkg::EDGES_WRITE : iossbc_pkg::EDGES_READ;
        if (!wr) spk_bit = ~spk_bit;
      end
      iossbc_pkg::GRP_DISPLAY: begin
        if (!n[3]) disp_flags[3'(iossbc_pkg::DF_TEXT + int'(n[2:1]))] = n[0];
        else if (!wr) ann_bits[n[2:1]] = ~n[0];
      end
      iossbc_pkg::GRP_BUTTON: begin
        if (!wr && (n inside {[4'h1:4'h3]}))
          r.read_data = status_byte(a.buttons[n[1:0] - 2'd1]);
      end
      iossbc_pkg::GRP_LC: begin
        lc_bits = '0;
        if (n[0]) begin
          lc_bits[iossbc_pkg::LC_WREN] = 1'b1;
          lc_bits[iossbc_pkg::LC_WRB2] = ~n[3];
        end
        if (n[1] == n[0]) begin
          lc_bits[iossbc_pkg::LC_READRAM] = 1'b1;
          lc_bits[iossbc_pkg::LC_BANK2] = ~n[3];
        end
      end
      default: ;
    endcase
    r.aux_read          = mm_flags[iossbc_pkg::MM_RAMRD];
    r.aux_write         = mm_flags[iossbc_pkg::MM_RAMWRT];
    r.aux_zero_page     = mm_flags[iossbc_pkg::MM_ALTZP];
    r.internal_slot_rom = mm_flags[iossbc_pkg::MM_INTCXROM];
    r.lc_mode           = lc_bits;
    r.switch_flags      = {disp_flags[iossbc_pkg::DF_HIRES],
                           disp_flags[iossbc_pkg::DF_PAGE2],
                           disp_flags[iossbc_pkg::DF_MIXED],
                           disp_flags[iossbc_pkg::DF_TEXT],
                           disp_flags[iossbc_pkg::DF_ALTCHARSET],
                           disp_flags[iossbc_pkg::DF_COL80],
                           mm_flags[iossbc_pkg::MM_SLOTC3ROM],
                           mm_flags[iossbc_pkg::MM_STORE80]};
    r.annunciators      = ann_bits;
    r.speaker_level     = spk_bit;
    return r;
  endfunction

  function automatic iossbc_pkg::access_t make_access(input logic m, input logic [7:0] off,
                                                      input logic [7:0] fill,
                                                      input logic [2:0] btn);
    iossbc_pkg::access_t a;
    a.mode        = m;
    a.io_offset   = off;
    a.key_data    = fill;
    a.anykey_data = fill;
    a.vblank_data = fill;
    a.buttons     = btn;
    return a;
  endfunction

  function automatic iossbc_pkg::result_t quiet_result(input logic [7:0] rd, input logic spk,
                                                       input logic [1:0] edges,
                                                       input logic strobe);
    iossbc_pkg::result_t r;
    r                  = '0;
    r.read_data        = rd;
    r.speaker_level    = spk;
    r.speaker_edges    = edges;
    r.key_strobe_clear = strobe;
    return r;
  endfunction

  function automatic iossbc_pkg::access_t random_access();
    iossbc_pkg::access_t a;
    logic [3:0]          grp;
    a.mode = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 6: grp = iossbc_pkg::GRP_SWITCH;
      1, 7: grp = iossbc_pkg::GRP_STATUS;
      2: grp = iossbc_pkg::GRP_SPEAKER;
      3: grp = iossbc_pkg::GRP_DISPLAY;
      4: grp = iossbc_pkg::GRP_BUTTON;
      5: grp = iossbc_pkg::GRP_LC;
      default: grp = 4'($urandom_range(15));
    endcase
    a.io_offset   = {grp, 4'($urandom_range(15))};
    a.key_data    = 8'($urandom_range(255));
    a.anykey_data = 8'($urandom_range(255));
    a.vblank_data = 8'($urandom_range(255));
    a.buttons     = 3'($urandom_range(7));
    return a;
  endfunction

  task automatic add_row(input logic m, input logic [7:0] off, input logic [7:0] fill,
                         input logic [2:0] btn, input logic typed,
                         input iossbc_pkg::result_t want);
    stim_row_t row;
    row.acc   = make_access(m, off, fill, btn);
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_access(input iossbc_pkg::access_t a, input logic typed,
                             input iossbc_pkg::result_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      access_valid <= 1'b0;
      @(negedge clk);
    end
    access_valid  <= 1'b1;
    access        <= a;
    pin_valid      = typed;
    pinned_result  = want;
    do @(posedge clk); while (access_stall);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // accepted access transaction
  always @(posedge clk) begin : accept_mon
    iossbc_pkg::result_t r;
    if (rst) begin
      mm_flags   = '0;
      disp_flags = '0;
      ann_bits   = '0;
      lc_bits    = '0;
      spk_bit    = 1'b0;
    end else if (access_valid && !access_stall) begin
      r = predict_access(access);
      if (pin_valid) r = pinned_result;
      pending_results.push_back(r);
    end
  end

  // result transaction
  always @(posedge clk) begin : result_mon
    iossbc_pkg::result_t w;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        w = pending_results.pop_front();
        check_field("read_data", w.read_data, result.read_data);
        check_field("aux_read", 8'(w.aux_read), 8'(result.aux_read));
        check_field("aux_write", 8'(w.aux_write), 8'(result.aux_write));
        check_field("aux_zero_page", 8'(w.aux_zero_page), 8'(result.aux_zero_page));
        check_field("internal_slot_rom", 8'(w.internal_slot_rom),
                    8'(result.internal_slot_rom));
        check_field("lc_mode", 8'(w.lc_mode), 8'(result.lc_mode));
        check_field("switch_flags", w.switch_flags, result.switch_flags);
        check_field("annunciators", 8'(w.annunciators), 8'(result.annunciators));
        check_field("speaker_level", 8'(w.speaker_level), 8'(result.speaker_level));
        check_field("speaker_edges", 8'(w.speaker_edges), 8'(result.speaker_edges));
        check_field("key_strobe_clear", 8'(w.key_strobe_clear),
                    8'(result.key_strobe_clear));
      end
    end
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL io_soft_switch_bank_control");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    access_valid   = 1'b0;
    access         = '0;
    pin_valid      = 1'b0;
    pinned_result  = '0;
    in_idle_pct    = 24;
    out_idle_pct   = 56;

    // state right after reset, data extremes, unmapped write, speaker
    add_row(MODE_READ, {iossbc_pkg::GRP_SWITCH, 4'h0}, 8'hFF, 3'd0, 1'b1,
            quiet_result(8'hFF, 1'b0, 2'd0, 1'b0));
    add_row(MODE_READ, {iossbc_pkg::GRP_STATUS, 4'h0}, 8'hA5, 3'd0, 1'b1,
            quiet_result(8'hA5, 1'b0, 2'd0, 1'b1));
    add_row(MODE_READ, {iossbc_pkg::GRP_STATUS, 4'h9}, 8'hFF, 3'd0, 1'b1,
            quiet_result(8'hFF, 1'b0, 2'd0, 1'b0));
    add_row(iossbc_pkg::MODE_WRITE, 8'hFF, 8'hFF, 3'd7, 1'b1,
            quiet_result(8'h00, 1'b0, 2'd0, 1'b0));
    add_row(MODE_READ, {iossbc_pkg::GRP_SPEAKER, 4'h0}, 8'h00, 3'd0, 1'b1,
            quiet_result(8'h00, 1'b1, iossbc_pkg::EDGES_READ, 1'b0));
    add_row(iossbc_pkg::MODE_WRITE, {iossbc_pkg::GRP_SPEAKER, 4'hF}, 8'h5A, 3'd0, 1'b1,
            quiet_result(8'h00, 1'b1, iossbc_pkg::EDGES_WRITE, 1'b0));
    // switch writes, status reads, display and annunciators
    add_row(iossbc_pkg::MODE_WRITE, {iossbc_pkg::GRP_SWITCH, 4'h1}, 8'h00, 3'd0, 1'b0, '0);
    add_row(iossbc_pkg::MODE_WRITE, {iossbc_pkg::GRP_SWITCH, 4'h3}, 8'h00, 3'd0, 1'b0, '0);
    add_row(iossbc_pkg::MODE_WRITE, {iossbc_pkg::GRP_SWITCH, 4'hD}, 8'h00, 3'd0, 1'b0, '0);
    add_row(iossbc_pkg::MODE_WRITE, {iossbc_pkg::GRP_SWITCH, 4'hF}, 8'h00, 3'd0, 1'b0, '0);
    add_row(MODE_READ, {iossbc_pkg::GRP_STATUS, 4'h8}, 8'h00, 3'd0, 1'b0, '0);
    add_row(MODE_READ, {iossbc_pkg::GRP_STATUS, 4'hF}, 8'h00, 3'd0, 1'b0, '0);
    add_row(iossbc_pkg::MODE_WRITE, {iossbc_pkg::GRP_DISPLAY, 4'h1}, 8'h00, 3'd0, 1'b0, '0);
    add_row(MODE_READ, {iossbc_pkg::GRP_DISPLAY, 4'h7}, 8'h00, 3'd0, 1'b0, '0);
    add_row(MODE_READ, {iossbc_pkg::GRP_DISPLAY, 4'h8}, 8'h00, 3'd0, 1'b0, '0);
    add_row(iossbc_pkg::MODE_WRITE, {iossbc_pkg::GRP_DISPLAY, 4'hA}, 8'h00, 3'd0, 1'b0, '0);
    add_row(MODE_READ, {iossbc_pkg::GRP_DISPLAY, 4'hF}, 8'h00, 3'd0, 1'b0, '0);
    // buttons and unmapped button offset
    add_row(MODE_READ, {iossbc_pkg::GRP_BUTTON, 4'h1}, 8'h00, 3'd7, 1'b0, '0);
    add_row(MODE_READ, {iossbc_pkg::GRP_BUTTON, 4'h3}, 8'h00, 3'd4, 1'b0, '0);
    add_row(MODE_READ, {iossbc_pkg::GRP_BUTTON, 4'h0}, 8'hFF, 3'd7, 1'b0, '0);
    // language card, bank2 forced low on rom read
    add_row(MODE_READ, {iossbc_pkg::GRP_LC, 4'h0}, 8'h00, 3'd0, 1'b0, '0);
    add_row(MODE_READ, {iossbc_pkg::GRP_STATUS, 4'h1}, 8'h00, 3'd0, 1'b0, '0);
    add_row(iossbc_pkg::MODE_WRITE, {iossbc_pkg::GRP_LC, 4'hB}, 8'h00, 3'd0, 1'b0, '0);
    add_row(MODE_READ, {iossbc_pkg::GRP_LC, 4'h9}, 8'h00, 3'd0, 1'b0, '0);
    add_row(iossbc_pkg::MODE_WRITE, {iossbc_pkg::GRP_STATUS, 4'h2}, 8'hFF, 3'd0, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct  = 24;
          out_idle_pct = 56;
        end
        1: begin
          in_idle_pct  = 56;
          out_idle_pct = 24;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_access(random_access(), 1'b0, '0);
    end
    access_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS io_soft_switch_bank_control");
    end else begin
      $display("FAIL io_soft_switch_bank_control");
    end
    $finish;
  end

endmodule
